// ----- rtl/core/ppc_pkg.sv -----
package ppc_pkg;

   // default geometry of the coordinate path
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   // signed distance width and configuration word widths
   localparam int DIST_W = 40;
   localparam int CFG_W = 32;
   localparam int MARGIN_W = 16;
   localparam int CSR_IDX_W = 3;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INSIDE_MARGIN = 3'd4;

   // reset value of the normal z component (1.0 in Q16.16)
   localparam logic [CFG_W-1:0] NORMAL_Z_RESET = 32'h0001_0000;

   // result slots of one vertex, in emit order
   localparam int EMIT_W = 3;
   localparam logic [EMIT_W-1:0] EM_KEEP_A = 3'd0;
   localparam logic [EMIT_W-1:0] EM_CROSS_A = 3'd1;
   localparam logic [EMIT_W-1:0] EM_KEEP_B = 3'd2;
   localparam logic [EMIT_W-1:0] EM_CROSS_B = 3'd3;
   localparam logic [EMIT_W-1:0] EM_EMPTY = 3'd4;
   localparam int EMIT_SLOTS = 5;

   // sequencer states
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_DLOAD  = 13'b0000000000010,
      S_MUL    = 13'b0000000000100,
      S_DACC   = 13'b0000000001000,
      S_DFIN   = 13'b0000000010000,
      S_PLAN   = 13'b0000000100000,
      S_NEXT   = 13'b0000001000000,
      S_XLOAD  = 13'b0000010000000,
      S_DIVSET = 13'b0000100000000,
      S_DIV    = 13'b0001000000000,
      S_XFIN   = 13'b0010000000000,
      S_EMIT   = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

endpackage

// ----- rtl/core/polygon_plane_clipper_top.sv -----
// per vertex, the plane distance is built from a bit-serial multiply per axis, each plane
// crossing from a multiply and a divide per axis, and each result waits while the output stalls;
// the bit-serial add/subtract unit is shared by all multiplies and divides, and no new
// vertex is taken until the previous one is finished.
// reset is synchronous, active high: clears the sequencer, polygon state and
// output valid flag and loads the configuration registers with their defaults.
module polygon_plane_clipper_top #(
   parameter int COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [COORD_WIDTH-1:0]   req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0]   req_vertex_y,
   input  logic signed [COORD_WIDTH-1:0]   req_vertex_z,
   input  logic                            req_last_vertex,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [COORD_WIDTH-1:0]   rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_out_z,
   output logic                            rsp_vertex_valid,
   output logic                            rsp_is_crossing,
   output logic                            rsp_end_of_polygon,
   output logic                            rsp_last_of_run,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ppc_pkg::CFG_W-1:0]       csr_data
);
   import ppc_pkg::*;

   // widths of the serial datapath
   localparam int LW = COORD_WIDTH + 1;            // multiplier / quotient field
   localparam int MW = DIST_W + 1;                 // multiplicand / divisor field
   localparam int PW = MW + LW;                    // full product / dividend
   localparam int AW = CFG_W + COORD_WIDTH + FRAC_BITS + 3;
   localparam int CNT_W = $clog2(LW + 1);
   localparam int SW = COORD_WIDTH + 3;            // crossing sum before saturation

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIST_W-1:0] dist_type;

   // configuration registers
   logic signed [CFG_W-1:0] normal_ff [3];
   logic signed [CFG_W-1:0] offset_ff;
   logic [MARGIN_W-1:0]     margin_ff;

   // sequencer and working registers
   state_type          state_ff, state_in;
   coord_type          vin_ff [3], vin_in [3];
   logic               last_ff, last_in;
   logic [1:0]         axis_ff, axis_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MW-1:0]      oper_ff, oper_in;
   logic [PW-1:0]      work_ff, work_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   dist_type           dist_ff, dist_in;
   logic               cross_mode_ff, cross_mode_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic               zden_ff, zden_in;
   logic [EMIT_SLOTS-1:0] pend_ff, pend_in;
   logic [EMIT_W-1:0]  sel_ff, sel_in;
   coord_type          xres_ff [3], xres_in [3];

   // polygon state
   coord_type          first_ff [3], first_in [3];
   dist_type           first_dist_ff, first_dist_in;
   coord_type          prev_ff [3], prev_in [3];
   dist_type           prev_dist_ff, prev_dist_in;
   logic [1:0]         seen_ff, seen_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   coord_type          rsp_pt_ff [3], rsp_pt_in [3];
   logic               rsp_vv_ff, rsp_vv_in;
   logic               rsp_cr_ff, rsp_cr_in;
   logic               rsp_eop_ff, rsp_eop_in;
   logic               rsp_lor_ff, rsp_lor_in;

   // shared add/subtract unit
   logic               su_sub;
   logic [MW:0]        su_a, su_b;
   logic [MW+1:0]      su_sum;

   always_comb begin
      su_sub = (state_ff == S_DIV);
      if (su_sub) begin
         su_a = work_ff[PW-1:LW-1];
         su_b = {1'b0, oper_ff};
      end else begin
         su_a = {1'b0, work_ff[PW-1:LW]};
         su_b = work_ff[0] ? {1'b0, oper_ff} : '0;
      end
      su_sum = {1'b0, su_a} + {1'b0, (su_sub ? ~su_b : su_b)} + {{(MW+1){1'b0}}, su_sub};
   end

   // distance operands for the current axis
   logic signed [CFG_W-1:0] n_cur;
   logic [CFG_W-1:0]        n_mag;
   coord_type               v_cur;
   logic [COORD_WIDTH-1:0]  v_mag;

   always_comb begin
      n_cur = normal_ff[axis_ff];
      v_cur = vin_ff[axis_ff];
      n_mag = n_cur[CFG_W-1] ? (~n_cur + 1'b1) : n_cur;
      v_mag = v_cur[COORD_WIDTH-1] ? (~v_cur + 1'b1) : v_cur;
   end

   // crossing operands: edge a runs prev -> vertex, edge b vertex -> first
   coord_type               cr_c, cr_n;
   dist_type                cr_dc, cr_dn;
   logic signed [LW-1:0]    cr_diff;
   logic [LW-1:0]           diff_mag;
   logic signed [MW-1:0]    cr_den;
   logic [MW-1:0]           den_mag;
   logic [MW-1:0]           dc_mag;

   always_comb begin
      if (sel_ff == EM_CROSS_B) begin
         cr_c = vin_ff[axis_ff];
         cr_n = first_ff[axis_ff];
         cr_dc = dist_ff;
         cr_dn = first_dist_ff;
      end else begin
         cr_c = prev_ff[axis_ff];
         cr_n = vin_ff[axis_ff];
         cr_dc = prev_dist_ff;
         cr_dn = dist_ff;
      end
      cr_diff = {cr_n[COORD_WIDTH-1], cr_n} - {cr_c[COORD_WIDTH-1], cr_c};
      diff_mag = cr_diff[LW-1] ? (~cr_diff + 1'b1) : cr_diff;
      cr_den = {cr_dc[DIST_W-1], cr_dc} - {cr_dn[DIST_W-1], cr_dn};
      den_mag = cr_den[MW-1] ? (~cr_den + 1'b1) : cr_den;
      dc_mag = cr_dc[DIST_W-1] ? MW'(-{cr_dc[DIST_W-1], cr_dc}) : {1'b0, cr_dc};
   end

   // crossing finish: curr +/- quotient, saturated
   logic [LW-1:0]        q_val;
   logic signed [SW-1:0] x_sum;
   coord_type            x_sat;

   always_comb begin
      if (zden_ff) begin
         q_val = '0;
      end else if (ovf_ff) begin
         q_val = {1'b1, {COORD_WIDTH{1'b0}}};
      end else begin
         q_val = work_ff[LW-1:0];
      end
      if (neg_ff) begin
         x_sum = {{(SW-COORD_WIDTH){cr_c[COORD_WIDTH-1]}}, cr_c} - {{(SW-LW){1'b0}}, q_val};
      end else begin
         x_sum = {{(SW-COORD_WIDTH){cr_c[COORD_WIDTH-1]}}, cr_c} + {{(SW-LW){1'b0}}, q_val};
      end
      if ((x_sum[SW-1:COORD_WIDTH-1] == '0) || (x_sum[SW-1:COORD_WIDTH-1] == '1)) begin
         x_sat = x_sum[COORD_WIDTH-1:0];
      end else if (x_sum[SW-1]) begin
         x_sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         x_sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   end

   // distance finish: floor shift and 40 bit saturation
   logic signed [AW-1:0] acc_sh;
   dist_type             dist_sat;

   always_comb begin
      acc_sh = acc_ff >>> FRAC_BITS;
      if ((acc_sh[AW-1:DIST_W-1] == '0) || (acc_sh[AW-1:DIST_W-1] == '1)) begin
         dist_sat = acc_sh[DIST_W-1:0];
      end else if (acc_sh[AW-1]) begin
         dist_sat = {1'b1, {(DIST_W-1){1'b0}}};
      end else begin
         dist_sat = {1'b0, {(DIST_W-1){1'b1}}};
      end
   end

   // inside tests and planned results
   logic                  in_prev, in_vert, in_first, edge_a, edge_b;
   logic [EMIT_SLOTS-1:0] plan;
   logic signed [DIST_W-1:0] margin_ext;

   always_comb begin
      margin_ext = {{(DIST_W-MARGIN_W){1'b0}}, margin_ff};
      in_prev = (prev_dist_ff <= margin_ext);
      in_vert = (dist_ff <= margin_ext);
      in_first = (first_dist_ff <= margin_ext);
      edge_a = last_ff ? (seen_ff >= 2'd2) : (seen_ff >= 2'd1);
      edge_b = last_ff && (seen_ff >= 2'd2);
      plan = '0;
      plan[EM_KEEP_A] = edge_a && in_prev;
      plan[EM_CROSS_A] = edge_a && (in_prev != in_vert);
      plan[EM_KEEP_B] = edge_b && in_vert;
      plan[EM_CROSS_B] = edge_b && (in_vert != in_first);
      plan[EM_EMPTY] = last_ff && (plan[EM_CROSS_B:EM_KEEP_A] == '0);
   end

   // lowest pending result slot
   logic [EMIT_W-1:0] pick;

   always_comb begin
      pick = EM_EMPTY;
      for (int i = EMIT_SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick = EMIT_W'(i);
         end
      end
   end

   logic [EMIT_SLOTS-1:0] pend_left;
   logic                  rsp_free;
   logic                  prod_neg;
   logic signed [AW-1:0]  prod_ext;

   assign pend_left = pend_ff & ~(EMIT_SLOTS'(1) << sel_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign prod_ext = {{(AW-PW){1'b0}}, work_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      vin_in = vin_ff;
      last_in = last_ff;
      axis_in = axis_ff;
      cnt_in = cnt_ff;
      oper_in = oper_ff;
      work_in = work_ff;
      acc_in = acc_ff;
      dist_in = dist_ff;
      cross_mode_in = cross_mode_ff;
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      zden_in = zden_ff;
      pend_in = pend_ff;
      sel_in = sel_ff;
      xres_in = xres_ff;
      first_in = first_ff;
      first_dist_in = first_dist_ff;
      prev_in = prev_ff;
      prev_dist_in = prev_dist_ff;
      seen_in = seen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pt_in = rsp_pt_ff;
      rsp_vv_in = rsp_vv_ff;
      rsp_cr_in = rsp_cr_ff;
      rsp_eop_in = rsp_eop_ff;
      rsp_lor_in = rsp_lor_ff;
      prod_neg = neg_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               vin_in[0] = req_vertex_x;
               vin_in[1] = req_vertex_y;
               vin_in[2] = req_vertex_z;
               last_in = req_last_vertex;
               axis_in = 2'd0;
               acc_in = -({{(AW-CFG_W){offset_ff[CFG_W-1]}}, offset_ff} <<< FRAC_BITS);
               state_in = S_DLOAD;
            end
         end
         S_DLOAD: begin
            oper_in = {{(MW-CFG_W){1'b0}}, n_mag};
            work_in = {{MW{1'b0}}, 1'b0, v_mag};
            neg_in = n_cur[CFG_W-1] ^ v_cur[COORD_WIDTH-1];
            cnt_in = CNT_W'(LW);
            cross_mode_in = 1'b0;
            state_in = S_MUL;
         end
         S_MUL: begin
            work_in = {su_sum[MW:0], work_ff[LW-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = cross_mode_ff ? S_DIVSET : S_DACC;
            end
         end
         S_DACC: begin
            acc_in = prod_neg ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
            if (axis_ff == 2'd2) begin
               state_in = S_DFIN;
            end else begin
               axis_in = axis_ff + 1'b1;
               state_in = S_DLOAD;
            end
         end
         S_DFIN: begin
            dist_in = dist_sat;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            pend_in = plan;
            state_in = (plan == '0) ? S_DONE : S_NEXT;
         end
         S_NEXT: begin
            sel_in = pick;
            axis_in = 2'd0;
            if ((pick == EM_CROSS_A) || (pick == EM_CROSS_B)) begin
               state_in = S_XLOAD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_XLOAD: begin
            oper_in = dc_mag;
            work_in = {{MW{1'b0}}, diff_mag};
            neg_in = cr_dc[DIST_W-1] ^ cr_diff[LW-1] ^ cr_den[MW-1];
            cnt_in = CNT_W'(LW);
            cross_mode_in = 1'b1;
            state_in = S_MUL;
         end
         S_DIVSET: begin
            zden_in = (cr_den == '0);
            ovf_in = (work_ff[PW-1:LW] >= den_mag);
            oper_in = den_mag;
            cnt_in = CNT_W'(LW);
            if ((cr_den == '0) || (work_ff[PW-1:LW] >= den_mag)) begin
               state_in = S_XFIN;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            work_in[LW-1:0] = {work_ff[LW-2:0], su_sum[MW+1]};
            work_in[PW-1:LW] = su_sum[MW+1] ? su_sum[MW-1:0] : su_a[MW-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               ovf_in = 1'b0;
               zden_in = 1'b0;
               state_in = S_XFIN;
            end
         end
         S_XFIN: begin
            xres_in[axis_ff] = x_sat;
            ovf_in = 1'b0;
            zden_in = 1'b0;
            if (axis_ff == 2'd2) begin
               state_in = S_EMIT;
            end else begin
               axis_in = axis_ff + 1'b1;
               state_in = S_XLOAD;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               case (sel_ff) inside
                  EM_KEEP_A: begin
                     rsp_pt_in = prev_ff;
                     rsp_vv_in = 1'b1;
                     rsp_cr_in = 1'b0;
                  end
                  EM_KEEP_B: begin
                     rsp_pt_in = vin_ff;
                     rsp_vv_in = 1'b1;
                     rsp_cr_in = 1'b0;
                  end
                  EM_CROSS_A, EM_CROSS_B: begin
                     rsp_pt_in = xres_ff;
                     rsp_vv_in = 1'b1;
                     rsp_cr_in = 1'b1;
                  end
                  default: begin
                     rsp_pt_in[0] = '0;
                     rsp_pt_in[1] = '0;
                     rsp_pt_in[2] = '0;
                     rsp_vv_in = 1'b0;
                     rsp_cr_in = 1'b0;
                  end
               endcase
               rsp_lor_in = (pend_left == '0);
               rsp_eop_in = last_ff && (pend_left == '0);
               pend_in = pend_left;
               state_in = (pend_left == '0) ? S_DONE : S_NEXT;
            end
         end
         S_DONE: begin
            if (last_ff) begin
               seen_in = 2'd0;
            end else begin
               if (seen_ff == 2'd0) begin
                  first_in = vin_ff;
                  first_dist_in = dist_ff;
               end
               prev_in = vin_ff;
               prev_dist_in = dist_ff;
               if (seen_ff < 2'd2) begin
                  seen_in = seen_ff + 1'b1;
               end
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and polygon state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         seen_ff <= 2'd0;
         cross_mode_ff <= 1'b0;
         ovf_ff <= 1'b0;
         zden_ff <= 1'b0;
         pend_ff <= '0;
         first_dist_ff <= '0;
         prev_dist_ff <= '0;
         for (int j = 0; j < 3; j++) begin
            first_ff[j] <= '0;
            prev_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff <= seen_in;
         cross_mode_ff <= cross_mode_in;
         ovf_ff <= ovf_in;
         zden_ff <= zden_in;
         pend_ff <= pend_in;
         first_dist_ff <= first_dist_in;
         prev_dist_ff <= prev_dist_in;
         first_ff <= first_in;
         prev_ff <= prev_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      vin_ff <= vin_in;
      last_ff <= last_in;
      axis_ff <= axis_in;
      cnt_ff <= cnt_in;
      oper_ff <= oper_in;
      work_ff <= work_in;
      acc_ff <= acc_in;
      dist_ff <= dist_in;
      neg_ff <= neg_in;
      sel_ff <= sel_in;
      xres_ff <= xres_in;
      rsp_pt_ff <= rsp_pt_in;
      rsp_vv_ff <= rsp_vv_in;
      rsp_cr_ff <= rsp_cr_in;
      rsp_eop_ff <= rsp_eop_in;
      rsp_lor_ff <= rsp_lor_in;
   end

   // configuration write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NORMAL_Z_RESET;
         offset_ff <= '0;
         margin_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NORMAL_X: normal_ff[0] <= csr_data;
            REG_NORMAL_Y: normal_ff[1] <= csr_data;
            REG_NORMAL_Z: normal_ff[2] <= csr_data;
            REG_PLANE_OFFSET: offset_ff <= csr_data;
            REG_INSIDE_MARGIN: margin_ff <= csr_data[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ports
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_pt_ff[0];
   assign rsp_out_y = rsp_pt_ff[1];
   assign rsp_out_z = rsp_pt_ff[2];
   assign rsp_vertex_valid = rsp_vv_ff;
   assign rsp_is_crossing = rsp_cr_ff;
   assign rsp_end_of_polygon = rsp_eop_ff;
   assign rsp_last_of_run = rsp_lor_ff;

endmodule

// ----- rtl/core/ppc_checker.sv -----
module ppc_checker #(
   parameter int COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_WIDTH-1:0] rsp_out_x,
   input logic                          rsp_vertex_valid,
   input logic                          rsp_is_crossing,
   input logic                          rsp_end_of_polygon,
   input logic                          rsp_last_of_run
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x))
      else $error("stalled result changed");

   // block is busy right after taking a vertex
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken back to back");

   // end of polygon closes the run
   a_eop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_polygon |-> rsp_last_of_run)
      else $error("end of polygon not last of run");

   // empty marker is the polygon end with a zero x coordinate
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_vertex_valid |->
         rsp_end_of_polygon && !rsp_is_crossing && (rsp_out_x == '0))
      else $error("malformed empty marker");

endmodule

bind polygon_plane_clipper_top ppc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppc_checker (.*);

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ppc_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int DW = 40;

   // one clipped-polygon result
   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
      logic          vld;
      logic          crs;
      logic          eop;
      logic          lor;
   } clip_rsp_type;

   // one vertex of the input stream
   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
      logic          last;
   } vtx_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_vertex_x = '0;
   logic signed [CW-1:0] req_vertex_y = '0;
   logic signed [CW-1:0] req_vertex_z = '0;
   logic req_last_vertex = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_vertex_valid, rsp_is_crossing, rsp_end_of_polygon, rsp_last_of_run;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   polygon_plane_clipper_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of registers and polygon state
   logic signed [31:0] pl_n [3];
   logic signed [31:0] pl_d;
   logic [15:0]        pl_margin;
   logic signed [CW-1:0] first_v [3];
   logic signed [CW-1:0] prev_v [3];
   logic signed [DW-1:0] first_dist, prev_dist;
   int unsigned          seen;

   clip_rsp_type clip_q[$];
   int  err_cnt = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   task automatic report(input string msg);
      $display("tb_top: mismatch: %s", msg);
      err_cnt++;
   endtask

   function automatic logic signed [DW-1:0] plane_dist(input logic signed [CW-1:0] p [3]);
      logic signed [127:0] acc;
      logic signed [127:0] sh;
      acc = 128'(pl_n[0]) * 128'(p[0]) + 128'(pl_n[1]) * 128'(p[1])
          + 128'(pl_n[2]) * 128'(p[2]) - (128'(pl_d) <<< FB);
      sh = acc >>> FB;
      if (sh > 128'sd549755813887) return 40'sh7F_FFFF_FFFF;
      if (sh < -128'sd549755813888) return 40'sh80_0000_0000;
      return sh[DW-1:0];
   endfunction

   function automatic logic signed [CW-1:0] cross_coord(input logic signed [CW-1:0] c,
         input logic signed [CW-1:0] n, input logic signed [DW-1:0] dc,
         input logic signed [DW-1:0] dn);
      logic signed [63:0] den, diff, dcw, r;
      logic [127:0] num, q;
      logic neg;
      den = 64'(dc) - 64'(dn);
      diff = 64'(n) - 64'(c);
      dcw = 64'(dc);
      if (den == 0) return c;
      num = 128'(dcw < 0 ? -dcw : dcw) * 128'(diff < 0 ? -diff : diff);
      q = num / 128'(den < 0 ? -den : den);
      if (q > (128'd1 << 60)) q = 128'd1 << 60;
      neg = (dcw < 0) ^ (diff < 0) ^ (den < 0);
      r = neg ? 64'(c) - 64'(q) : 64'(c) + 64'(q);
      if (r > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (r < -64'sd2147483648) return 32'sh8000_0000;
      return r[CW-1:0];
   endfunction

   function automatic clip_rsp_type mk_rsp(input logic signed [CW-1:0] p [3],
         input logic vld, input logic crs);
      clip_rsp_type r;
      r.x = p[0]; r.y = p[1]; r.z = p[2];
      r.vld = vld; r.crs = crs; r.eop = 1'b0; r.lor = 1'b0;
      return r;
   endfunction

   // one edge: kept start and/or crossing
   task automatic clip_edge(input logic signed [CW-1:0] c [3], input logic signed [DW-1:0] dc,
         input logic signed [CW-1:0] n [3], input logic signed [DW-1:0] dn,
         inout clip_rsp_type res[$]);
      logic signed [CW-1:0] x [3];
      logic cin, nin;
      cin = dc <= $signed({24'd0, pl_margin});
      nin = dn <= $signed({24'd0, pl_margin});
      if (cin) res = {res, mk_rsp(c, 1'b1, 1'b0)};
      if (cin != nin) begin
         for (int j = 0; j < 3; j++) x[j] = cross_coord(c[j], n[j], dc, dn);
         res = {res, mk_rsp(x, 1'b1, 1'b1)};
      end
   endtask

   task automatic predict_vertex(input vtx_type v);
      logic signed [CW-1:0] p [3];
      logic signed [CW-1:0] zero [3];
      logic signed [DW-1:0] vdist;
      clip_rsp_type res[$];
      p[0] = v.x; p[1] = v.y; p[2] = v.z;
      zero[0] = '0; zero[1] = '0; zero[2] = '0;
      vdist = plane_dist(p);
      if (!v.last) begin
         if (seen >= 1) clip_edge(prev_v, prev_dist, p, vdist, res);
         if (seen == 0) begin
            first_v = p;
            first_dist = vdist;
         end
         prev_v = p;
         prev_dist = vdist;
         if (seen < 2) seen++;
      end else begin
         if (seen >= 2) begin
            clip_edge(prev_v, prev_dist, p, vdist, res);
            clip_edge(p, vdist, first_v, first_dist, res);
         end
         if (res.size() == 0) res = {res, mk_rsp(zero, 1'b0, 1'b0)};
         res[res.size()-1].eop = 1'b1;
         seen = 0;
      end
      if (res.size() > 0) res[res.size()-1].lor = 1'b1;
      clip_q = {clip_q, res};
   endtask

   // result checker
   always @(posedge clock) begin
      clip_rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (clip_q.size() == 0) begin
            report("result with nothing expected");
         end else begin
            exp_r = clip_q.pop_front();
            if (rsp_vertex_valid !== exp_r.vld || rsp_is_crossing !== exp_r.crs ||
                rsp_end_of_polygon !== exp_r.eop || rsp_last_of_run !== exp_r.lor ||
                rsp_out_x !== exp_r.x || rsp_out_y !== exp_r.y || rsp_out_z !== exp_r.z)
               report($sformatf("got %h %h %h %b%b%b%b exp %h %h %h %b%b%b%b",
                  rsp_out_x, rsp_out_y, rsp_out_z, rsp_vertex_valid, rsp_is_crossing,
                  rsp_end_of_polygon, rsp_last_of_run, exp_r.x, exp_r.y, exp_r.z,
                  exp_r.vld, exp_r.crs, exp_r.eop, exp_r.lor));
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_vertex(input vtx_type v);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_vertex_x <= v.x;
      req_vertex_y <= v.y;
      req_vertex_z <= v.z;
      req_last_vertex <= v.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_vertex(v);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (clip_q.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_NORMAL_X: pl_n[0] = val;
         REG_NORMAL_Y: pl_n[1] = val;
         REG_NORMAL_Z: pl_n[2] = val;
         REG_PLANE_OFFSET: pl_d = val;
         REG_INSIDE_MARGIN: pl_margin = val[15:0];
         default: ;
      endcase
   endtask

   function automatic vtx_type mk_vtx(input int x, input int y, input int z, input bit last);
      vtx_type v;
      v.x = x; v.y = y; v.z = z; v.last = last;
      return v;
   endfunction

   // random coordinate: mostly small, sometimes any 32-bit value
   function automatic logic [CW-1:0] rnd_coord();
      if ($urandom_range(9) == 0) return $urandom;
      return $signed($urandom_range(20 << 16)) - (10 << 16);
   endfunction

   // random polygon of nv vertices; callers pick a short/broken one now and then
   task automatic send_polygon(input int nv);
      for (int i = 0; i < nv; i++)
         send_vertex(mk_vtx(rnd_coord(), rnd_coord(), rnd_coord(), i == nv - 1));
   endtask

   // directed table: vertex plus expected results where obvious
   typedef struct {
      vtx_type      v;
      int           n_exp;
      clip_rsp_type e0;
   } dir_row_type;

   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      clip_rsp_type empty_eop;
      int n;
      pl_n[0] = 0; pl_n[1] = 0; pl_n[2] = NORMAL_Z_RESET; pl_d = 0; pl_margin = 0;
      first_v = '{0, 0, 0}; prev_v = '{0, 0, 0};
      first_dist = 0; prev_dist = 0; seen = 0;
      empty_eop = '{x: 0, y: 0, z: 0, vld: 0, crs: 0, eop: 1, lor: 1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single vertex and two-vertex polygons: empty end marker only
      row.n_exp = 1; row.e0 = empty_eop;
      row.v = mk_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1); rows.push_front(row);
      row.n_exp = 0;
      row.v = mk_vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0); rows = {rows, row};
      row.n_exp = 1;
      row.v = mk_vtx(-1, -1, -1, 1); rows = {rows, row};
      // triangle fully inside, fully outside, straddling
      row.n_exp = -1;
      row.v = mk_vtx(0, 0, -65536, 0); rows = {rows, row};
      row.v = mk_vtx(65536, 0, -65536, 0); rows = {rows, row};
      row.v = mk_vtx(0, 65536, -65536, 1); rows = {rows, row};
      row.v = mk_vtx(0, 0, 65536, 0); rows = {rows, row};
      row.v = mk_vtx(65536, 0, 65536, 0); rows = {rows, row};
      row.n_exp = 1;
      row.v = mk_vtx(0, 65536, 65536, 1); rows = {rows, row};
      row.n_exp = -1;
      row.v = mk_vtx(0, 0, -65536, 0); rows = {rows, row};
      row.v = mk_vtx(65536, 0, 65536, 0); rows = {rows, row};
      row.v = mk_vtx(0, 65536, 0, 0); rows = {rows, row};
      row.v = mk_vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1); rows = {rows, row};
      // extremes straddling the plane
      row.v = mk_vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0); rows = {rows, row};
      row.v = mk_vtx(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0); rows = {rows, row};
      row.v = mk_vtx(32'h7FFF_FFFF, 32'h8000_0000, 1, 1); rows = {rows, row};

      foreach (rows[i]) begin
         // sender holds off until every expected result has come
         while (clip_q.size() != 0) @(posedge clock);
         n = clip_q.size();
         send_vertex(rows[i].v);
         if (rows[i].n_exp >= 0 && clip_q.size() - n != rows[i].n_exp)
            report($sformatf("directed row %0d result count", i));
         if (rows[i].n_exp == 1 && clip_q[clip_q.size()-1] !== rows[i].e0)
            report($sformatf("directed row %0d result", i));
      end
      drain();

      // register extremes, all registers written
      csr_write(REG_NORMAL_X, 32'h7FFF_FFFF);
      csr_write(REG_NORMAL_Y, 32'h8000_0000);
      csr_write(REG_NORMAL_Z, 32'h7FFF_FFFF);
      csr_write(REG_PLANE_OFFSET, 32'h8000_0000);
      csr_write(REG_INSIDE_MARGIN, 32'h0000_FFFF);
      for (int i = 0; i < 4; i++) send_polygon($urandom_range(5, 3));
      drain();

      // random phases with differing planes, idling and receiver stalls
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(REG_NORMAL_X, ph == 5 ? 32'h8000_0000 : $signed($urandom_range(131072)) - 65536);
         csr_write(REG_NORMAL_Y, ph == 5 ? 32'h7FFF_FFFF : $signed($urandom_range(131072)) - 65536);
         csr_write(REG_NORMAL_Z, ph == 0 ? 32'h0 : $urandom);
         csr_write(REG_PLANE_OFFSET, ph == 1 ? 32'h7FFF_FFFF : $signed($urandom_range(8 << 16)) - (4 << 16));
         csr_write(REG_INSIDE_MARGIN, ph == 2 ? 32'h0 : $urandom_range(16'hFFFF));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         for (int k = 0; k < 12; k++) begin
            if ($urandom_range(9) == 0) send_polygon($urandom_range(2, 1));
            else send_polygon($urandom_range(6, 3));
            // halfway through, the sender holds off until all results are back
            if (k == 5) while (clip_q.size() != 0) @(posedge clock);
         end
         drain();
      end

      if (err_cnt == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #100ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
